// ----- hw/rtl/vrp_pkg.sv -----
// vrp_pkg: shared widths, codes and request/response types of the video register port
// used by vrp_cfg, vrp_vmem and the top level; no dependencies
`default_nettype none

package vrp_pkg;

  // field widths
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned REG_W    = 3;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned VADDR_W  = 14;
  localparam int unsigned TADDR_W  = 15;
  localparam int unsigned FX_W     = 3;
  localparam int unsigned MIRROR_W = 2;

  // memory sizes
  localparam int unsigned PATTERN_BYTES       = 8192;
  localparam int unsigned SPRITE_MEM_BYTES    = 256;
  localparam int unsigned PALETTE_BYTES       = 32;
  localparam int unsigned NAMETABLE_BYTES_DEF = 4096;
  localparam int unsigned SPR_AW              = $clog2(SPRITE_MEM_BYTES);

  // video address map
  localparam logic [VADDR_W-1:0] NT_BASE  = 14'h2000;
  localparam logic [VADDR_W-1:0] PAL_BASE = 14'h3F00;

  // item actions
  localparam logic [ACT_W-1:0] ACT_READ       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_VBLANK     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRERENDER  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SPRITE0    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SOFT_RESET = 3'd5;

  // cpu-visible registers
  localparam logic [REG_W-1:0] REG_CTRL     = 3'd0;
  localparam logic [REG_W-1:0] REG_MASK     = 3'd1;
  localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
  localparam logic [REG_W-1:0] REG_OAM_ADDR = 3'd3;
  localparam logic [REG_W-1:0] REG_OAM_DATA = 3'd4;
  localparam logic [REG_W-1:0] REG_SCROLL   = 3'd5;
  localparam logic [REG_W-1:0] REG_ADDR     = 3'd6;
  localparam logic [REG_W-1:0] REG_DATA     = 3'd7;

  // nametable mirroring
  localparam logic [MIRROR_W-1:0] MIRROR_VERT = 2'd0;
  localparam logic [MIRROR_W-1:0] MIRROR_HORZ = 2'd1;
  localparam logic [MIRROR_W-1:0] MIRROR_FOUR = 2'd2;
  localparam logic [MIRROR_W-1:0] MIRROR_ALT  = 2'd3;

  // configuration port
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic        CFG_IDX_MIRROR = 1'b0;

  // memory access request from the register logic
  typedef struct packed {
    logic                vram_we;
    logic [VADDR_W-1:0]  vram_waddr;
    logic                spr_we;
    logic [SPR_AW-1:0]   spr_waddr;
    logic [DATA_W-1:0]   wdata;
    logic [VADDR_W-1:0]  vram_raddr;
    logic [SPR_AW-1:0]   spr_raddr;
  } mem_req_t;

  // registered read data and clear status back from the memories
  typedef struct packed {
    logic                busy;
    logic [DATA_W-1:0]   vram_rdata;
    logic [DATA_W-1:0]   spr_rdata;
  } mem_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vrp_cfg.sv -----
// vrp_cfg: apb-style configuration register (nametable mirroring mode)
// depends on vrp_pkg
`default_nettype none

module vrp_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready,
  output logic      [vrp_pkg::MIRROR_W-1:0]   mirror_mode
);
  import vrp_pkg::*;

  logic                cfg_wr;
  logic                sel_mirror;
  logic [MIRROR_W-1:0] mirror_r;
  logic [MIRROR_W-1:0] mirror_nxt;

  // word select and write strobe
  assign sel_mirror = (paddr[2] == CFG_IDX_MIRROR);
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  // code three behaves as four-screen
  always_comb begin
    mirror_nxt = mirror_r;
    if (cfg_wr && sel_mirror) begin
      if (pwdata[MIRROR_W-1:0] == MIRROR_ALT) begin
        mirror_nxt = MIRROR_FOUR;
      end else begin
        mirror_nxt = pwdata[MIRROR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= MIRROR_VERT;
    end else begin
      mirror_r <= mirror_nxt;
    end
  end

  // read back
  assign prdata      = sel_mirror ? {{(CFG_DATA_W-MIRROR_W){1'b0}}, mirror_r} : '0;
  assign mirror_mode = mirror_r;

endmodule

`default_nettype wire

// ----- hw/rtl/vrp_vmem.sv -----
// vrp_vmem: pattern, nametable and sprite rams, palette registers, address mapping
// and the post-reset clearing sweep; depends on vrp_pkg
`default_nettype none

module vrp_vmem #(
  parameter int unsigned NT_BYTES = vrp_pkg::NAMETABLE_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vrp_pkg::mem_req_t           req,
  input  wire logic [vrp_pkg::MIRROR_W-1:0] mirror_mode,
  output vrp_pkg::mem_rsp_t                rsp
);
  import vrp_pkg::*;

  localparam int unsigned NT_AW  = $clog2(NT_BYTES);
  localparam int unsigned PAT_AW = $clog2(PATTERN_BYTES);
  localparam int unsigned PAL_AW = $clog2(PALETTE_BYTES);
  // one bit above the 12-bit folded nametable offset
  localparam int unsigned NT_IW  = 13;

  localparam logic [1:0] REGION_PAT = 2'd0;
  localparam logic [1:0] REGION_NT  = 2'd1;
  localparam logic [1:0] REGION_PAL = 2'd2;

  // which memory an address falls in
  function automatic logic [1:0] region_of(input logic [VADDR_W-1:0] a);
    logic [1:0] rg;
    if (a < NT_BASE) begin
      rg = REGION_PAT;
    end else if (a < PAL_BASE) begin
      rg = REGION_NT;
    end else begin
      rg = REGION_PAL;
    end
    return rg;
  endfunction

  // nametable fold, mirroring, then wrap into the physical size
  function automatic logic [NT_AW-1:0] nt_map(input logic [VADDR_W-1:0] a,
                                              input logic [MIRROR_W-1:0] mode);
    logic [NT_IW-1:0] idx;
    case (mode)
      MIRROR_VERT: idx = {2'b00, a[10:0]};
      MIRROR_HORZ: idx = {2'b00, a[11], a[9:0]};
      default:     idx = {1'b0, a[11:0]};
    endcase
    if (idx >= NT_IW'(NT_BYTES)) begin
      idx = idx - NT_IW'(NT_BYTES);
    end
    return idx[NT_AW-1:0];
  endfunction

  // backdrop entries of the sprite palettes alias onto the background ones
  function automatic logic [PAL_AW-1:0] pal_index(input logic [VADDR_W-1:0] a);
    logic [PAL_AW-1:0] p;
    p = a[PAL_AW-1:0];
    if ((p & 5'h13) == 5'h10) begin
      p = p & 5'h0F;
    end
    return p;
  endfunction

  logic              busy_r;
  logic [PAT_AW-1:0] clr_cnt_r;

  logic [1:0]        wr_region;
  logic [1:0]        rd_region;
  logic [1:0]        rd_region_r;
  logic [DATA_W-1:0] wdata;

  logic              pat_we;
  logic [PAT_AW-1:0] pat_waddr;
  logic [PAT_AW-1:0] pat_raddr;
  logic [DATA_W-1:0] pat_rdata_r;
  logic [DATA_W-1:0] pat_mem [PATTERN_BYTES];

  logic              nt_we;
  logic [NT_AW-1:0]  nt_waddr;
  logic [NT_AW-1:0]  nt_raddr;
  logic [DATA_W-1:0] nt_rdata_r;
  logic [DATA_W-1:0] nt_mem [NT_BYTES];

  logic              spr_we;
  logic [SPR_AW-1:0] spr_waddr;
  logic [DATA_W-1:0] spr_rdata_r;
  logic [DATA_W-1:0] spr_mem [SPRITE_MEM_BYTES];

  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [PAL_AW-1:0] pal_raddr;
  logic [DATA_W-1:0] pal_rdata_r;
  logic [DATA_W-1:0] pal_r [PALETTE_BYTES];

  // clearing sweep, one entry of every ram per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == PAT_AW'(PATTERN_BYTES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // port steering: the sweep owns the write ports while busy
  always_comb begin
    wr_region = region_of(req.vram_waddr);
    rd_region = region_of(req.vram_raddr);
    wdata     = busy_r ? '0 : req.wdata;

    pat_we    = busy_r || (req.vram_we && (wr_region == REGION_PAT));
    pat_waddr = busy_r ? clr_cnt_r : req.vram_waddr[PAT_AW-1:0];
    pat_raddr = req.vram_raddr[PAT_AW-1:0];

    nt_we     = busy_r ? (clr_cnt_r < PAT_AW'(NT_BYTES))
                       : (req.vram_we && (wr_region == REGION_NT));
    nt_waddr  = busy_r ? clr_cnt_r[NT_AW-1:0] : nt_map(req.vram_waddr, mirror_mode);
    nt_raddr  = nt_map(req.vram_raddr, mirror_mode);

    spr_we    = busy_r ? (clr_cnt_r < PAT_AW'(SPRITE_MEM_BYTES)) : req.spr_we;
    spr_waddr = busy_r ? clr_cnt_r[SPR_AW-1:0] : req.spr_waddr;

    pal_we    = !busy_r && req.vram_we && (wr_region == REGION_PAL);
    pal_waddr = pal_index(req.vram_waddr);
    pal_raddr = pal_index(req.vram_raddr);
  end

  // pattern ram, write-first on a same-address read
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= wdata;
    end
    pat_rdata_r <= (pat_we && (pat_waddr == pat_raddr)) ? wdata : pat_mem[pat_raddr];
  end

  // nametable ram
  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_waddr] <= wdata;
    end
    nt_rdata_r <= (nt_we && (nt_waddr == nt_raddr)) ? wdata : nt_mem[nt_raddr];
  end

  // sprite ram
  always_ff @(posedge clk) begin
    if (spr_we) begin
      spr_mem[spr_waddr] <= wdata;
    end
    spr_rdata_r <= (spr_we && (spr_waddr == req.spr_raddr)) ? wdata
                                                            : spr_mem[req.spr_raddr];
  end

  // palette registers, cleared directly by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r <= '{default: '0};
    end else if (pal_we) begin
      pal_r[pal_waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    pal_rdata_r <= (pal_we && (pal_waddr == pal_raddr)) ? wdata : pal_r[pal_raddr];
    rd_region_r <= rd_region;
  end

  // read data select by the region the read was issued for
  always_comb begin
    rsp.busy      = busy_r;
    rsp.spr_rdata = spr_rdata_r;
    case (rd_region_r)
      REGION_PAT: rsp.vram_rdata = pat_rdata_r;
      REGION_NT:  rsp.vram_rdata = nt_rdata_r;
      default:    rsp.vram_rdata = pal_rdata_r;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/video_register_port_with_vram_unit.sv -----
// Video register port: a word is registered at accept and its result word is registered
// when the word is processed; throughput one word per cycle while the result channel
// does not stall, set by the single registered ram read per word, which is issued ahead
// from the next pointer. rst_n is synchronous; after it the rams are swept to zero
// up to the pattern size, during which in_ready stays low; config writes are taken
// throughout. Depends on vrp_pkg, vrp_cfg, vrp_vmem.
`default_nettype none

module video_register_port_with_vram_unit #(
  parameter int unsigned NAMETABLE_BYTES = vrp_pkg::NAMETABLE_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // item channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [vrp_pkg::ACT_W-1:0]      in_action,
  input  wire logic [vrp_pkg::REG_W-1:0]      in_reg_index,
  input  wire logic [vrp_pkg::DATA_W-1:0]     in_write_data,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [vrp_pkg::DATA_W-1:0]     out_read_data,
  output logic                                out_nmi_pulse,
  output logic      [vrp_pkg::VADDR_W-1:0]    out_current_addr,
  output logic      [vrp_pkg::TADDR_W-1:0]    out_temp_addr,
  output logic      [vrp_pkg::FX_W-1:0]       out_fine_x_scroll,
  output logic      [vrp_pkg::DATA_W-1:0]     out_control_value,
  output logic      [vrp_pkg::DATA_W-1:0]     out_mask_value,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import vrp_pkg::*;

  localparam logic [VADDR_W-1:0] STEP_ROW = VADDR_W'(32);
  localparam logic [VADDR_W-1:0] STEP_COL = VADDR_W'(1);

  logic [MIRROR_W-1:0] mirror_mode;
  mem_req_t            mem_req;
  mem_rsp_t            mem_rsp;

  // input register
  logic              in_valid_r;
  logic [ACT_W-1:0]  in_act_r;
  logic [REG_W-1:0]  in_reg_r;
  logic [DATA_W-1:0] in_data_r;
  logic              in_accept;
  logic              proc_fire;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r;
  logic              out_nmi_r;
  logic [DATA_W-1:0] rd_nxt;
  logic              nmi_nxt;

  // architectural state
  logic [DATA_W-1:0]  ctrl_r,    ctrl_nxt;
  logic [DATA_W-1:0]  mask_r,    mask_nxt;
  logic               vbl_r,     vbl_nxt;
  logic               s0_r,      s0_nxt;
  logic [VADDR_W-1:0] ptr_r,     ptr_nxt;
  logic [TADDR_W-1:0] tmp_r,     tmp_nxt;
  logic [FX_W-1:0]    fx_r,      fx_nxt;
  logic               tog_r,     tog_nxt;
  logic [DATA_W-1:0]  rbuf_r,    rbuf_nxt;
  logic [DATA_W-1:0]  obus_r,    obus_nxt;
  logic [SPR_AW-1:0]  spr_ptr_r, spr_ptr_nxt;
  logic [VADDR_W-1:0] ptr_inc;

  vrp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mirror_mode (mirror_mode)
  );

  vrp_vmem #(
    .NT_BYTES (NAMETABLE_BYTES)
  ) u_vmem (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (mem_req),
    .mirror_mode (mirror_mode),
    .rsp         (mem_rsp)
  );

  // handshake: a word is processed when the result slot is free or being emptied
  assign proc_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !mem_rsp.busy && (!in_valid_r || proc_fire);
  assign in_accept = in_valid && in_ready;
  assign ptr_inc   = ctrl_r[2] ? STEP_ROW : STEP_COL;

  // register port behavior for the word in the input register
  always_comb begin
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    vbl_nxt     = vbl_r;
    s0_nxt      = s0_r;
    ptr_nxt     = ptr_r;
    tmp_nxt     = tmp_r;
    fx_nxt      = fx_r;
    tog_nxt     = tog_r;
    rbuf_nxt    = rbuf_r;
    obus_nxt    = obus_r;
    spr_ptr_nxt = spr_ptr_r;
    rd_nxt      = '0;
    nmi_nxt     = 1'b0;
    mem_req     = '0;

    if (proc_fire) begin
      unique case (in_act_r)
        ACT_READ: begin
          case (in_reg_r)
            REG_STATUS: begin
              // overflow flag is never raised here
              rd_nxt  = {vbl_r, s0_r, 6'b0};
              vbl_nxt = 1'b0;
              tog_nxt = 1'b0;
            end
            REG_OAM_DATA: begin
              rd_nxt = mem_rsp.spr_rdata;
            end
            REG_DATA: begin
              // palette reads bypass the buffer
              rd_nxt   = (ptr_r >= PAL_BASE) ? mem_rsp.vram_rdata : rbuf_r;
              rbuf_nxt = mem_rsp.vram_rdata;
              ptr_nxt  = ptr_r + ptr_inc;
            end
            default: begin
              rd_nxt = obus_r;
            end
          endcase
          obus_nxt = rd_nxt;
        end
        ACT_WRITE: begin
          obus_nxt = in_data_r;
          case (in_reg_r)
            REG_CTRL: begin
              ctrl_nxt = in_data_r;
              tmp_nxt  = {tmp_r[14:12], in_data_r[1:0], tmp_r[9:0]};
            end
            REG_MASK: begin
              mask_nxt = in_data_r;
            end
            REG_OAM_ADDR: begin
              spr_ptr_nxt = in_data_r;
            end
            REG_OAM_DATA: begin
              mem_req.spr_we = 1'b1;
              spr_ptr_nxt    = spr_ptr_r + 1'b1;
            end
            REG_SCROLL: begin
              if (!tog_r) begin
                tmp_nxt = {tmp_r[14:5], in_data_r[7:3]};
                fx_nxt  = in_data_r[2:0];
                tog_nxt = 1'b1;
              end else begin
                tmp_nxt = {in_data_r[2:0], tmp_r[11:10], in_data_r[7:3], tmp_r[4:0]};
                tog_nxt = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!tog_r) begin
                tmp_nxt = {1'b0, in_data_r[5:0], tmp_r[7:0]};
                tog_nxt = 1'b1;
              end else begin
                tmp_nxt = {tmp_r[14:8], in_data_r};
                ptr_nxt = {tmp_r[13:8], in_data_r};
                tog_nxt = 1'b0;
              end
            end
            REG_DATA: begin
              mem_req.vram_we = 1'b1;
              ptr_nxt         = ptr_r + ptr_inc;
            end
            default: begin
              // status write only touches the open bus byte
            end
          endcase
        end
        ACT_VBLANK: begin
          vbl_nxt = 1'b1;
          nmi_nxt = ctrl_r[7];
        end
        ACT_PRERENDER: begin
          vbl_nxt = 1'b0;
          s0_nxt  = 1'b0;
        end
        ACT_SPRITE0: begin
          s0_nxt = 1'b1;
        end
        ACT_SOFT_RESET: begin
          ctrl_nxt = '0;
          mask_nxt = '0;
          s0_nxt   = 1'b0;
          ptr_nxt  = '0;
          tmp_nxt  = '0;
          fx_nxt   = '0;
          tog_nxt  = 1'b0;
          rbuf_nxt = '0;
        end
        default: begin
          // unused actions leave the state alone
        end
      endcase
    end

    // write at the current pointer, read one word ahead at the next one
    mem_req.vram_waddr = ptr_r;
    mem_req.spr_waddr  = spr_ptr_r;
    mem_req.wdata      = in_data_r;
    mem_req.vram_raddr = ptr_nxt;
    mem_req.spr_raddr  = spr_ptr_nxt;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= '0;
      mask_r      <= '0;
      vbl_r       <= 1'b0;
      s0_r        <= 1'b0;
      ptr_r       <= '0;
      tmp_r       <= '0;
      fx_r        <= '0;
      tog_r       <= 1'b0;
      rbuf_r      <= '0;
      obus_r      <= '0;
      spr_ptr_r   <= '0;
    end else begin
      in_valid_r  <= in_accept || (in_valid_r && !proc_fire);
      out_valid_r <= proc_fire || (out_valid_r && !out_ready);
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      vbl_r       <= vbl_nxt;
      s0_r        <= s0_nxt;
      ptr_r       <= ptr_nxt;
      tmp_r       <= tmp_nxt;
      fx_r        <= fx_nxt;
      tog_r       <= tog_nxt;
      rbuf_r      <= rbuf_nxt;
      obus_r      <= obus_nxt;
      spr_ptr_r   <= spr_ptr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_act_r  <= in_action;
      in_reg_r  <= in_reg_index;
      in_data_r <= in_write_data;
    end
    if (proc_fire) begin
      out_rd_r  <= rd_nxt;
      out_nmi_r <= nmi_nxt;
    end
  end

  // state only moves together with a new result word, so it is the result state
  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_nmi_pulse     = out_nmi_r;
  assign out_current_addr  = ptr_r;
  assign out_temp_addr     = tmp_r;
  assign out_fine_x_scroll = fx_r;
  assign out_control_value = ctrl_r;
  assign out_mask_value    = mask_r;

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rsp.busy |-> !in_ready)
    else $error("word accepted during ram clearing sweep");

  a_word_held_until_processed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc_fire) |=> in_valid_r)
    else $error("input word dropped before processing");

  a_vblank_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && (in_act_r == ACT_VBLANK)) |=> vbl_r)
    else $error("vblank event did not raise the flag");

  a_data_access_steps_pointer: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && (in_reg_r == REG_DATA) &&
     ((in_act_r == ACT_READ) || (in_act_r == ACT_WRITE)))
    |=> (ptr_r == ($past(ptr_r) + $past(ptr_inc))))
    else $error("data access did not step the vram pointer");

  a_nmi_only_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nmi_r) |-> (out_rd_r == '0))
    else $error("nmi pulse on a word that returned read data");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for video_register_port_with_vram_unit, cpu register words
// and frame events in, one state word out per item, predicted in-line and checked
// depends on vrp_pkg and the register port rtl
module tb;
  import vrp_pkg::*;

  // item actions with no function in the port
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] MIRROR_PADDR = CFG_ADDR_W'(4 * CFG_IDX_MIRROR);

  localparam int unsigned WATCHDOG_LIMIT = 30000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_WORDS    = 240;
  localparam int unsigned NUM_PHASES     = 5;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [REG_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } cpu_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rd;
    logic               nmi;
    logic [VADDR_W-1:0] vaddr;
    logic [TADDR_W-1:0] taddr;
    logic [FX_W-1:0]    fx;
    logic [DATA_W-1:0]  ctrl;
    logic [DATA_W-1:0]  mask;
  } port_state_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [ACT_W-1:0]      in_action     = '0;
  logic [REG_W-1:0]      in_reg_index  = '0;
  logic [DATA_W-1:0]     in_write_data = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [DATA_W-1:0]     out_read_data;
  logic                  out_nmi_pulse;
  logic [VADDR_W-1:0]    out_current_addr;
  logic [TADDR_W-1:0]    out_temp_addr;
  logic [FX_W-1:0]       out_fine_x_scroll;
  logic [DATA_W-1:0]     out_control_value;
  logic [DATA_W-1:0]     out_mask_value;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  video_register_port_with_vram_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_reg_index      (in_reg_index),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_nmi_pulse     (out_nmi_pulse),
    .out_current_addr  (out_current_addr),
    .out_temp_addr     (out_temp_addr),
    .out_fine_x_scroll (out_fine_x_scroll),
    .out_control_value (out_control_value),
    .out_mask_value    (out_mask_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted port state, zero at reset like the block's memories
  bit [MIRROR_W-1:0] mirror_sel;
  bit [7:0]  ctrl_r, mask_r, status_r, rd_buf, bus_latch, spr_ptr;
  bit [13:0] vaddr_r;
  bit [14:0] taddr_r;
  bit [2:0]  fine_x_r;
  bit        toggle_r;
  bit [7:0]  spr_mem [SPRITE_MEM_BYTES];
  bit [7:0]  nt_mem  [NAMETABLE_BYTES_DEF];
  bit [7:0]  pal_mem [PALETTE_BYTES];
  bit [7:0]  pat_mem [PATTERN_BYTES];

  cpu_word_t   pending_q[$];
  port_state_t result_q[$];

  int unsigned words_queued = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_request = 1'b0;
  bit          word_taken   = 1'b0;
  bit [31:0]   recv_cycle   = '0;

  // nametable slot after folding and mirroring
  function automatic int unsigned nt_slot(bit [13:0] a);
    bit [13:0] n;
    n = (a & 14'h2FFF) - NT_BASE;
    case (mirror_sel)
      MIRROR_VERT: n = n & 14'h07FF;
      MIRROR_HORZ: n = (n & 14'h03FF) | ((n >= 14'h0800) ? 14'h0400 : 14'h0000);
      default:     n = n & 14'h0FFF;
    endcase
    return n % NAMETABLE_BYTES_DEF;
  endfunction

  // palette slot, sprite backdrop entries fold onto the background ones
  function automatic int unsigned pal_slot(bit [13:0] a);
    bit [4:0] p;
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) p[4] = 1'b0;
    return p;
  endfunction

  // apply one cpu word or frame event and return the port state after it
  function automatic port_state_t apply_word(cpu_word_t w);
    port_state_t r;
    bit [7:0]    d;
    bit [13:0]   stride;
    r = '0;
    d = '0;
    stride = ctrl_r[2] ? 14'd32 : 14'd1;
    case (w.act)
      ACT_READ: begin
        case (w.idx)
          REG_STATUS: begin
            d = status_r;
            status_r[7] = 1'b0;
            toggle_r = 1'b0;
          end
          REG_OAM_DATA: d = spr_mem[spr_ptr];
          REG_DATA: begin
            // buffered read, palette bytes come back at once
            d = rd_buf;
            if (vaddr_r < NT_BASE) rd_buf = pat_mem[vaddr_r];
            else if (vaddr_r < PAL_BASE) rd_buf = nt_mem[nt_slot(vaddr_r)];
            else begin
              rd_buf = pal_mem[pal_slot(vaddr_r)];
              d = rd_buf;
            end
            vaddr_r = vaddr_r + stride;
          end
          default: d = bus_latch;
        endcase
        bus_latch = d;
        r.rd = d;
      end
      ACT_WRITE: begin
        bus_latch = w.data;
        case (w.idx)
          REG_CTRL: begin
            ctrl_r = w.data;
            taddr_r[11:10] = w.data[1:0];
          end
          REG_MASK:     mask_r = w.data;
          REG_OAM_ADDR: spr_ptr = w.data;
          REG_OAM_DATA: begin
            spr_mem[spr_ptr] = w.data;
            spr_ptr++;
          end
          REG_SCROLL: begin
            if (!toggle_r) begin
              taddr_r[4:0] = w.data[7:3];
              fine_x_r = w.data[2:0];
            end else begin
              taddr_r[14:12] = w.data[2:0];
              taddr_r[9:5] = w.data[7:3];
            end
            toggle_r = !toggle_r;
          end
          REG_ADDR: begin
            if (!toggle_r) taddr_r = {1'b0, w.data[5:0], taddr_r[7:0]};
            else begin
              taddr_r[7:0] = w.data;
              vaddr_r = taddr_r[13:0];
            end
            toggle_r = !toggle_r;
          end
          REG_DATA: begin
            if (vaddr_r < NT_BASE) pat_mem[vaddr_r] = w.data;
            else if (vaddr_r < PAL_BASE) nt_mem[nt_slot(vaddr_r)] = w.data;
            else pal_mem[pal_slot(vaddr_r)] = w.data;
            vaddr_r = vaddr_r + stride;
          end
          default: ;
        endcase
      end
      ACT_VBLANK: begin
        status_r[7] = 1'b1;
        r.nmi = ctrl_r[7];
      end
      ACT_PRERENDER: status_r = status_r & 8'h1F;
      ACT_SPRITE0:   status_r[6] = 1'b1;
      ACT_SOFT_RESET: begin
        ctrl_r = '0;
        mask_r = '0;
        status_r = status_r & 8'h80;
        vaddr_r = '0;
        taddr_r = '0;
        fine_x_r = '0;
        toggle_r = 1'b0;
        rd_buf = '0;
      end
      default: ;
    endcase
    r.vaddr = vaddr_r;
    r.taddr = taddr_r;
    r.fx    = fine_x_r;
    r.ctrl  = ctrl_r;
    r.mask  = mask_r;
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin : drive_proc
    logic      nxt_valid;
    cpu_word_t w;
    nxt_valid = in_valid;
    if (word_taken) begin
      nxt_valid = 1'b0;
      word_taken = 1'b0;
    end
    if (!nxt_valid && rst_n) begin
      if (gap_left > 0) gap_left--;
      else if (pending_q.size() > 0) begin
        w = pending_q.pop_front();
        nxt_valid = 1'b1;
        in_action <= w.act;
        in_reg_index <= w.idx;
        in_write_data <= w.data;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 23);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // receiver: rotating stall pattern, plus one long hold on request
  always @(negedge clk) begin : recv_proc
    recv_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (recv_cycle[7:6])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
        2'd2:    out_ready <= (recv_cycle[1:0] != 2'd0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result check, prediction of accepted words and watchdog
  always @(posedge clk) begin : check_proc
    port_state_t want;
    if (out_valid && out_ready) begin
      idle_cycles = 0;
      results_seen++;
      if (result_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result word with nothing expected", $time);
      end else begin
        want = result_q.pop_front();
        if (out_read_data !== want.rd || out_nmi_pulse !== want.nmi ||
            out_current_addr !== want.vaddr || out_temp_addr !== want.taddr ||
            out_fine_x_scroll !== want.fx || out_control_value !== want.ctrl ||
            out_mask_value !== want.mask) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp rd=%h nmi=%b va=%h ta=%h fx=%h ctl=%h msk=%h",
                     $time, want.rd, want.nmi, want.vaddr, want.taddr, want.fx,
                     want.ctrl, want.mask);
            $display("%0t:          got rd=%h nmi=%b va=%h ta=%h fx=%h ctl=%h msk=%h",
                     $time, out_read_data, out_nmi_pulse, out_current_addr,
                     out_temp_addr, out_fine_x_scroll, out_control_value, out_mask_value);
          end
        end
      end
    end
    if (in_valid && in_ready) begin
      idle_cycles = 0;
      result_q.push_back(apply_word({in_action, in_reg_index, in_write_data}));
      word_taken = 1'b1;
    end
    if (!(out_valid && out_ready) && !(in_valid && in_ready)) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_word(logic [ACT_W-1:0] a, logic [REG_W-1:0] i, logic [DATA_W-1:0] d);
    pending_q.push_back({a, i, d});
    words_queued++;
  endtask

  // wait until every queued word has come back
  task automatic wait_drained();
    do @(negedge clk); while (results_seen != words_queued);
  endtask

  // apb write of the mirroring register
  task automatic set_mirror(logic [MIRROR_W-1:0] code);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MIRROR_PADDR;
    pwdata <= CFG_DATA_W'(code);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mirror_sel = (code == MIRROR_ALT) ? MIRROR_FOUR : code;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one random sequence: mostly well-formed register sequences, some noise
  task automatic push_random_seq();
    logic [13:0] va;
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // address pair then a run of data accesses
        if ($urandom_range(0, 1) == 1) push_word(ACT_READ, REG_STATUS, 8'($urandom));
        if ($urandom_range(0, 3) == 0) push_word(ACT_WRITE, REG_CTRL, 8'($urandom));
        case ($urandom_range(0, 8))
          0:       va[13:8] = 6'h00;
          1:       va[13:8] = 6'h1F;
          2:       va[13:8] = 6'h20;
          3:       va[13:8] = 6'h24;
          4:       va[13:8] = 6'h28;
          5:       va[13:8] = 6'h2C;
          6:       va[13:8] = 6'h34;
          7:       va[13:8] = 6'h3F;
          default: va[13:8] = 6'($urandom);
        endcase
        va[7:0] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        push_word(ACT_WRITE, REG_ADDR, {2'($urandom), va[13:8]});
        push_word(ACT_WRITE, REG_ADDR, va[7:0]);
        n = $urandom_range(1, 6);
        repeat (n) push_word(($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ,
                             REG_DATA, 8'($urandom));
      end
      4: begin
        // sprite memory fill and read back
        va[7:0] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(250, 255)) : 8'($urandom);
        push_word(ACT_WRITE, REG_OAM_ADDR, va[7:0]);
        n = $urandom_range(1, 8);
        repeat (n) push_word(ACT_WRITE, REG_OAM_DATA, 8'($urandom));
        push_word(ACT_WRITE, REG_OAM_ADDR, va[7:0]);
        push_word(ACT_READ, REG_OAM_DATA, 8'($urandom));
      end
      5: begin
        if ($urandom_range(0, 1) == 1) push_word(ACT_READ, REG_STATUS, 8'($urandom));
        push_word(ACT_WRITE, REG_SCROLL, 8'($urandom));
        push_word(ACT_WRITE, REG_SCROLL, 8'($urandom));
      end
      6: begin
        if ($urandom_range(0, 5) == 0) push_word(ACT_SOFT_RESET, 3'($urandom), 8'($urandom));
        else push_word(3'($urandom_range(ACT_VBLANK, ACT_SPRITE0)), 3'($urandom),
                       8'($urandom));
      end
      7: begin
        if ($urandom_range(0, 1) == 1)
          push_word(ACT_WRITE, ($urandom_range(0, 1) == 1) ? REG_CTRL : REG_MASK,
                    8'($urandom));
        else push_word(ACT_READ, 3'($urandom), 8'($urandom));
      end
      default: push_word(3'($urandom), 3'($urandom), 8'($urandom));
    endcase
  endtask

  initial begin : stim_proc
    int unsigned target;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    set_mirror(MIRROR_VERT);

    // directed: flags, nmi, open bus, sprite wrap, scroll, address wrap, palette, buffer
    push_word(ACT_WRITE, REG_CTRL, 8'hFF);
    push_word(ACT_WRITE, REG_MASK, 8'hFF);
    push_word(ACT_VBLANK, REG_CTRL, 8'h00);
    push_word(ACT_SPRITE0, REG_CTRL, 8'h00);
    push_word(ACT_READ, REG_STATUS, 8'hFF);
    push_word(ACT_PRERENDER, REG_CTRL, 8'h00);
    push_word(ACT_WRITE, REG_STATUS, 8'h3C);
    push_word(ACT_READ, REG_CTRL, 8'h00);
    push_word(ACT_WRITE, REG_OAM_ADDR, 8'hFF);
    push_word(ACT_WRITE, REG_OAM_DATA, 8'hA5);
    push_word(ACT_WRITE, REG_OAM_ADDR, 8'hFF);
    push_word(ACT_READ, REG_OAM_DATA, 8'h00);
    push_word(ACT_WRITE, REG_SCROLL, 8'hFF);
    push_word(ACT_WRITE, REG_SCROLL, 8'h00);
    push_word(ACT_WRITE, REG_ADDR, 8'hFF);
    push_word(ACT_WRITE, REG_ADDR, 8'hFF);
    push_word(ACT_WRITE, REG_DATA, 8'h5A);
    push_word(ACT_WRITE, REG_ADDR, 8'h3F);
    push_word(ACT_WRITE, REG_ADDR, 8'h1F);
    push_word(ACT_READ, REG_DATA, 8'h00);
    push_word(ACT_WRITE, REG_CTRL, 8'h00);
    push_word(ACT_VBLANK, REG_STATUS, 8'h00);
    push_word(ACT_SOFT_RESET, REG_DATA, 8'hFF);
    push_word(ACT_RSVD6, REG_DATA, 8'hFF);
    push_word(ACT_RSVD7, REG_CTRL, 8'h00);
    // mirrored nametable read through the buffer
    push_word(ACT_WRITE, REG_ADDR, 8'h20);
    push_word(ACT_WRITE, REG_ADDR, 8'h00);
    push_word(ACT_WRITE, REG_DATA, 8'h77);
    push_word(ACT_WRITE, REG_ADDR, 8'h28);
    push_word(ACT_WRITE, REG_ADDR, 8'h00);
    push_word(ACT_READ, REG_DATA, 8'h00);
    push_word(ACT_READ, REG_DATA, 8'h00);
    wait_drained();

    // random phases, one mirroring setting each
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_mirror(MIRROR_HORZ);
        1:       set_mirror(MIRROR_FOUR);
        2:       set_mirror(MIRROR_ALT);
        3:       set_mirror(MIRROR_VERT);
        default: set_mirror(MIRROR_HORZ);
      endcase
      if (ph == 1) hold_request = 1'b1;
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) push_random_seq();
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (result_q.size() != 0) error_count++;
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
